// ===== sv/acpu_pkg.sv =====
// Shared types and constants for the accumulator processor step block.
`timescale 1ns / 1ps
`default_nettype none

package acpu_pkg;

	// Request codes
	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_READ    = 2'd1,
		REQ_RESTART = 2'd2,
		REQ_EXEC    = 2'd3
	} req_type_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_HALT    = 2'd1,
		ST_ILLEGAL = 2'd2,
		ST_IDLE    = 2'd3
	} status_t;

	// Opcodes
	localparam logic [7:0] OP_HLT = 8'h00;
	localparam logic [7:0] OP_LDA = 8'h01;
	localparam logic [7:0] OP_STA = 8'h02;
	localparam logic [7:0] OP_ADD = 8'h03;
	localparam logic [7:0] OP_SUB = 8'h04;
	localparam logic [7:0] OP_JMP = 8'h05;

	// Input item
	typedef struct packed {
		req_type_t   req_type;
		logic [7:0]  addr;
		logic [7:0]  data_in;
	} req_t;

	// Result item
	typedef struct packed {
		logic [7:0]  read_data;
		logic [7:0]  acc_out;
		logic [7:0]  pc_out;
		logic [7:0]  instr_out;
		logic        is_running;
		status_t     status;
	} rsp_t;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RDATA,
		S_OPC,
		S_OPR,
		S_JMP,
		S_EXEC,
		S_DONE
	} ctrl_state_t;

	// Memory address source
	typedef enum logic [1:0] {
		ADDR_REQ,
		ADDR_PC,
		ADDR_MEM
	} addr_sel_t;

	// Memory write data source
	typedef enum logic {
		WD_REQ,
		WD_ACC
	} wd_sel_t;

	typedef enum logic [1:0] {
		PC_HOLD,
		PC_INC,
		PC_LOAD,
		PC_CLEAR
	} pc_op_t;

	typedef enum logic [1:0] {
		IR_HOLD,
		IR_LOAD,
		IR_CLEAR
	} ir_op_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB,
		ACC_CLEAR
	} acc_op_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic       in_load;
		addr_sel_t  addr_sel;
		logic       mem_re;
		logic       mem_we;
		wd_sel_t    wd_sel;
		pc_op_t     pc_op;
		ir_op_t     ir_op;
		acc_op_t    acc_op;
		logic       run_set;
		logic       run_clr;
		logic       rd_capture;
		logic       st_load;
		status_t    st_val;
		logic       out_load;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		req_type_t  req_type;
		logic       running;
		logic [7:0] opcode;
		logic [7:0] ir;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

// ===== sv/accumulator_cpu_step.sv =====
// Top level of the accumulator processor step block.
//
// Requests arrive on req (req_valid/req_stall); each one produces exactly one
// result on rsp (rsp_valid/rsp_stall). A transfer happens on a rising edge
// with valid high and stall low. One request is in work at a time: req_stall
// is high from the transfer of a request until its result is loaded into the
// output register.
// The controller sequences each request over the single memory port with
// registered read data: write, restart and a step while stopped go from
// decode to done; a read adds a read-data state; a step fetches the opcode,
// then HLT or an illegal opcode stops, JMP loads the PC from the next byte,
// STA stores the accumulator at the address in the next byte, and LDA, ADD
// and SUB read from that address and then update the accumulator.
// When the receiver stalls, the result waits in the output register and a
// following request may still be taken and worked; it then waits to load.
// Reset clears the processor registers, the result valid and the per-byte
// written flags, so all memory reads as zero until written. MEM_DEPTH sets
// the memory size; addresses at or above it read zero and ignore writes.
`timescale 1ns / 1ps
`default_nettype none

module accumulator_cpu_step #(
	parameter int MEM_DEPTH = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire acpu_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output acpu_pkg::rsp_t      rsp
);

	acpu_pkg::cmd_t cmd;
	acpu_pkg::sts_t sts;

	acpu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	acpu_dp #(
		.MEM_DEPTH (MEM_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== sv/acpu_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module acpu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/acpu_ctrl.sv =====
// Sequencing state machine for the accumulator processor step block.
`timescale 1ns / 1ps
`default_nettype none

module acpu_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire acpu_pkg::sts_t sts,
	output acpu_pkg::cmd_t     cmd
);

	acpu_pkg::ctrl_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= acpu_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			acpu_pkg::S_IDLE: begin
				if (req_valid) state_d = acpu_pkg::S_DECODE;
			end
			acpu_pkg::S_DECODE: begin
				unique case (sts.req_type)
					acpu_pkg::REQ_READ: state_d = acpu_pkg::S_RDATA;
					acpu_pkg::REQ_EXEC: state_d = sts.running ? acpu_pkg::S_OPC
					                                           : acpu_pkg::S_DONE;
					default:            state_d = acpu_pkg::S_DONE;
				endcase
			end
			acpu_pkg::S_RDATA: state_d = acpu_pkg::S_DONE;
			acpu_pkg::S_OPC: begin
				case (sts.opcode) inside
					acpu_pkg::OP_LDA, acpu_pkg::OP_STA,
					acpu_pkg::OP_ADD, acpu_pkg::OP_SUB: state_d = acpu_pkg::S_OPR;
					acpu_pkg::OP_JMP:                   state_d = acpu_pkg::S_JMP;
					default:                            state_d = acpu_pkg::S_DONE;
				endcase
			end
			acpu_pkg::S_OPR: begin
				state_d = (sts.ir == acpu_pkg::OP_STA) ? acpu_pkg::S_DONE
				                                       : acpu_pkg::S_EXEC;
			end
			acpu_pkg::S_JMP:  state_d = acpu_pkg::S_DONE;
			acpu_pkg::S_EXEC: state_d = acpu_pkg::S_DONE;
			acpu_pkg::S_DONE: begin
				if (sts.out_free) state_d = acpu_pkg::S_IDLE;
			end
			default: state_d = acpu_pkg::S_IDLE;
		endcase
	end

	// Command outputs
	always_comb begin
		cmd            = '0;
		cmd.addr_sel   = acpu_pkg::ADDR_PC;
		cmd.wd_sel     = acpu_pkg::WD_REQ;
		cmd.pc_op      = acpu_pkg::PC_HOLD;
		cmd.ir_op      = acpu_pkg::IR_HOLD;
		cmd.acc_op     = acpu_pkg::ACC_HOLD;
		cmd.st_val     = acpu_pkg::ST_OK;
		req_stall      = (state_q != acpu_pkg::S_IDLE);
		unique case (state_q)
			acpu_pkg::S_IDLE: begin
				cmd.in_load = req_valid;
			end
			acpu_pkg::S_DECODE: begin
				unique case (sts.req_type)
					acpu_pkg::REQ_WRITE: begin
						cmd.addr_sel = acpu_pkg::ADDR_REQ;
						cmd.mem_we   = 1'b1;
					end
					acpu_pkg::REQ_READ: begin
						cmd.addr_sel = acpu_pkg::ADDR_REQ;
						cmd.mem_re   = 1'b1;
					end
					acpu_pkg::REQ_RESTART: begin
						cmd.pc_op   = acpu_pkg::PC_CLEAR;
						cmd.ir_op   = acpu_pkg::IR_CLEAR;
						cmd.acc_op  = acpu_pkg::ACC_CLEAR;
						cmd.run_set = 1'b1;
					end
					default: begin
						if (sts.running) begin
							// opcode fetch
							cmd.mem_re = 1'b1;
							cmd.pc_op  = acpu_pkg::PC_INC;
						end else begin
							cmd.st_load = 1'b1;
							cmd.st_val  = acpu_pkg::ST_IDLE;
						end
					end
				endcase
			end
			acpu_pkg::S_RDATA: begin
				cmd.rd_capture = 1'b1;
			end
			acpu_pkg::S_OPC: begin
				cmd.ir_op = acpu_pkg::IR_LOAD;
				case (sts.opcode) inside
					acpu_pkg::OP_LDA, acpu_pkg::OP_STA,
					acpu_pkg::OP_ADD, acpu_pkg::OP_SUB: begin
						// operand address fetch
						cmd.mem_re = 1'b1;
						cmd.pc_op  = acpu_pkg::PC_INC;
					end
					acpu_pkg::OP_JMP: begin
						cmd.mem_re = 1'b1;
					end
					acpu_pkg::OP_HLT: begin
						cmd.run_clr = 1'b1;
						cmd.st_load = 1'b1;
						cmd.st_val  = acpu_pkg::ST_HALT;
					end
					default: begin
						cmd.run_clr = 1'b1;
						cmd.st_load = 1'b1;
						cmd.st_val  = acpu_pkg::ST_ILLEGAL;
					end
				endcase
			end
			acpu_pkg::S_OPR: begin
				cmd.addr_sel = acpu_pkg::ADDR_MEM;
				if (sts.ir == acpu_pkg::OP_STA) begin
					cmd.mem_we = 1'b1;
					cmd.wd_sel = acpu_pkg::WD_ACC;
				end else begin
					cmd.mem_re = 1'b1;
				end
			end
			acpu_pkg::S_JMP: begin
				cmd.pc_op = acpu_pkg::PC_LOAD;
			end
			acpu_pkg::S_EXEC: begin
				case (sts.ir)
					acpu_pkg::OP_ADD: cmd.acc_op = acpu_pkg::ACC_ADD;
					acpu_pkg::OP_SUB: cmd.acc_op = acpu_pkg::ACC_SUB;
					default:          cmd.acc_op = acpu_pkg::ACC_LOAD;
				endcase
			end
			acpu_pkg::S_DONE: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== sv/acpu_dp.sv =====
// Datapath: processor registers, memory, valid bits and result register.
`timescale 1ns / 1ps
`default_nettype none

module acpu_dp #(
	parameter int MEM_DEPTH = 256
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire acpu_pkg::req_t req,
	input  wire acpu_pkg::cmd_t cmd,
	output acpu_pkg::sts_t      sts,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output acpu_pkg::rsp_t      rsp
);

	localparam int         AW        = $clog2(MEM_DEPTH);
	localparam int         VLD_N     = 1 << AW;
	localparam logic [8:0] DEPTH_LIM = 9'(MEM_DEPTH);

	acpu_pkg::req_t   req_q;
	logic [7:0]       acc_q, pc_q, ir_q, rd_q;
	logic             run_q;
	acpu_pkg::status_t st_q;
	logic [VLD_N-1:0] vld_q;
	logic             rvld_q;
	logic             rsp_valid_q;
	acpu_pkg::rsp_t   rsp_q;

	logic [7:0]       maddr, wdata, mdata, ram_rdata, acc_d;
	logic [AW-1:0]    ram_addr;
	logic             in_range, mem_we;

	// Memory address and write data selection
	always_comb begin
		unique case (cmd.addr_sel)
			acpu_pkg::ADDR_REQ: maddr = req_q.addr;
			acpu_pkg::ADDR_MEM: maddr = mdata;
			default:            maddr = pc_q;
		endcase
	end

	assign wdata    = (cmd.wd_sel == acpu_pkg::WD_ACC) ? acc_q : req_q.data_in;
	assign in_range = ({1'b0, maddr} < DEPTH_LIM);
	assign ram_addr = maddr[AW-1:0];
	assign mem_we   = cmd.mem_we && in_range;

	acpu_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (cmd.mem_re),
		.addr  (ram_addr),
		.wdata (wdata),
		.rdata (ram_rdata)
	);

	// Written-entry flags: unwritten or out-of-range bytes read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (mem_we) vld_q[ram_addr] <= 1'b1;
			if (cmd.mem_re) rvld_q <= in_range && vld_q[ram_addr];
		end
	end

	assign mdata = rvld_q ? ram_rdata : 8'h00;

	// Accumulator update
	always_comb begin
		case (cmd.acc_op)
			acpu_pkg::ACC_LOAD:  acc_d = mdata;
			acpu_pkg::ACC_ADD:   acc_d = acc_q + mdata;
			acpu_pkg::ACC_SUB:   acc_d = acc_q - mdata;
			acpu_pkg::ACC_CLEAR: acc_d = 8'h00;
			default:             acc_d = acc_q;
		endcase
	end

	// Architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 8'h00;
			pc_q  <= 8'h00;
			ir_q  <= 8'h00;
			run_q <= 1'b0;
		end else begin
			acc_q <= acc_d;
			case (cmd.pc_op)
				acpu_pkg::PC_INC:   pc_q <= pc_q + 8'd1;
				acpu_pkg::PC_LOAD:  pc_q <= mdata;
				acpu_pkg::PC_CLEAR: pc_q <= 8'h00;
				default:            pc_q <= pc_q;
			endcase
			case (cmd.ir_op)
				acpu_pkg::IR_LOAD:  ir_q <= mdata;
				acpu_pkg::IR_CLEAR: ir_q <= 8'h00;
				default:            ir_q <= ir_q;
			endcase
			if (cmd.run_set) run_q <= 1'b1;
			else if (cmd.run_clr) run_q <= 1'b0;
		end
	end

	// Request capture, read data and status of the current item
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			req_q <= req;
			rd_q  <= 8'h00;
			st_q  <= acpu_pkg::ST_OK;
		end else begin
			if (cmd.rd_capture) rd_q <= mdata;
			if (cmd.st_load) st_q <= cmd.st_val;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q.read_data  <= rd_q;
			rsp_q.acc_out    <= acc_q;
			rsp_q.pc_out     <= pc_q;
			rsp_q.instr_out  <= ir_q;
			rsp_q.is_running <= run_q;
			rsp_q.status     <= st_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status to the controller
	assign sts.req_type = req_q.req_type;
	assign sts.running  = run_q;
	assign sts.opcode   = mdata;
	assign sts.ir       = ir_q;
	assign sts.out_free = !rsp_valid_q || !rsp_stall;

endmodule

`default_nettype wire

// ===== sv/acpu_chk.sv =====
// Port-level checker for the accumulator processor step block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module acpu_chk (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire acpu_pkg::rsp_t rsp
);

	// A stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	// Only one request in work: a transfer closes the input next cycle
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in work");

	// Halt, illegal and ignored-step results report a stopped processor
	a_stopped: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == acpu_pkg::ST_HALT ||
		              rsp.status == acpu_pkg::ST_ILLEGAL ||
		              rsp.status == acpu_pkg::ST_IDLE) |-> !rsp.is_running)
		else $error("stop status with processor running");

	// A halt result shows the HLT opcode in the instruction register
	a_halt_ir: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == acpu_pkg::ST_HALT |-> rsp.instr_out == acpu_pkg::OP_HLT)
		else $error("halt status without HLT opcode");

endmodule

bind accumulator_cpu_step acpu_chk u_acpu_chk (.*);

`default_nettype wire
